// File: rtl/spr_rot_pkg.sv
// Package for the sprite pixel rotator: sprite and panel geometry, word types,
// and the Q1.14 sine table with its lookup function. No dependencies.
`timescale 1ns / 1ps

package spr_rot_pkg;

    localparam int SPRITE_SIZE  = 48;
    localparam int PANEL_WIDTH  = 84;
    localparam int PANEL_HEIGHT = 48;

    // Doubled offsets fit 8 signed bits for any sprite size up to 64.
    localparam int OFS_W  = 8;
    localparam int TRIG_W = 16;
    localparam int PROD_W = OFS_W + TRIG_W;
    // Panel coordinates times 2^15 fit 25 signed bits for panels up to 256.
    localparam int ACC_W  = 25;
    localparam int FRAC_W = 15;
    localparam int COORD_W = ACC_W - FRAC_W;

    localparam logic signed [OFS_W-1:0] SPRITE_SPAN = OFS_W'(SPRITE_SIZE - 1);
    localparam logic signed [ACC_W-1:0] CENTER_X_Q  = ACC_W'((PANEL_WIDTH - 1) * 16384);
    localparam logic signed [ACC_W-1:0] CENTER_Y_Q  = ACC_W'((PANEL_HEIGHT - 1) * 16384);
    localparam logic [ACC_W-1:0]        HALF_Q      = ACC_W'(16384);

    typedef struct packed {
        logic [5:0] src_col;
        logic [5:0] src_row;
        logic [7:0] heading_code;
    } t_in_word;

    typedef struct packed {
        logic [6:0] dest_col;
        logic [2:0] dest_bank;
        logic [2:0] dest_bit;
        logic       on_panel;
    } t_out_word;

    localparam logic [14:0] QUARTER_SINE [0:64] = '{
        15'd0,     15'd402,   15'd804,   15'd1205,  15'd1606,  15'd2006,  15'd2404,  15'd2801,
        15'd3196,  15'd3590,  15'd3981,  15'd4370,  15'd4756,  15'd5139,  15'd5520,  15'd5897,
        15'd6270,  15'd6639,  15'd7005,  15'd7366,  15'd7723,  15'd8076,  15'd8423,  15'd8765,
        15'd9102,  15'd9434,  15'd9760,  15'd10080, 15'd10394, 15'd10702, 15'd11003, 15'd11297,
        15'd11585, 15'd11866, 15'd12140, 15'd12406, 15'd12665, 15'd12916, 15'd13160, 15'd13395,
        15'd13623, 15'd13842, 15'd14053, 15'd14256, 15'd14449, 15'd14635, 15'd14811, 15'd14978,
        15'd15137, 15'd15286, 15'd15426, 15'd15557, 15'd15679, 15'd15791, 15'd15893, 15'd15986,
        15'd16069, 15'd16143, 15'd16207, 15'd16261, 15'd16305, 15'd16340, 15'd16364, 15'd16379,
        15'd16384
    };

    function automatic logic signed [TRIG_W-1:0] sine_q14(input logic [7:0] code);
        logic [6:0]  idx;
        logic [15:0] mag;
        idx = code[6] ? 7'(7'd64 - {1'b0, code[5:0]}) : {1'b0, code[5:0]};
        mag = {1'b0, QUARTER_SINE[idx]};
        return code[7] ? -signed'(mag) : signed'(mag);
    endfunction

endpackage

// File: rtl/sprite_pixel_rotator_unit.sv
// Top level of the sprite pixel rotator: input register, rotation datapath and
// result register with valid/stall handshakes. Depends on spr_rot_pkg and spr_rot_map.
`timescale 1ns / 1ps
//
//   Channel   Valid         Stall         Word
//   input     i_in_valid    o_in_stall    i_in_word  (t_in_word)
//   output    o_out_valid   i_out_stall   o_out_word (t_out_word)
//
// One word is accepted per cycle while o_in_stall is low; it passes from the input register
// through the datapath into the result register once that register is free or being taken.
// Latency is set by the input register and the result register around the datapath.
// Reset empties both registers; no word is lost or repeated across stalls.
// The input side stalls only when both registers are full and the output is stalled.

module sprite_pixel_rotator_unit
    import spr_rot_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    t_out_word n_out_word;
    logic      advance;

    spr_rot_map u_map (
        .i_word (r_in_word),
        .o_word (n_out_word)
    );

    assign advance     = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_word <= n_out_word;
        end
        if (!o_in_stall && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    a_off_panel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_word.on_panel) |->
            (r_out_word.dest_col == 7'd0 && r_out_word.dest_bank == 3'd0
             && r_out_word.dest_bit == 3'd0))
        else $error("off-panel result carries nonzero position");

    a_on_panel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.on_panel) |->
            (r_out_word.dest_col < 7'(PANEL_WIDTH)
             && {r_out_word.dest_bank, r_out_word.dest_bit} < 6'(PANEL_HEIGHT)))
        else $error("on-panel result outside the panel");

    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance) |=> r_out_valid)
        else $error("held word did not move to the result register");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled while a register was free");

endmodule

// File: rtl/spr_rot_map.sv
// Rotation datapath: rotates one sprite pixel and places it on the panel, or marks it off-panel.
// Purely combinational; uses spr_rot_pkg for geometry, types and the sine table.
`timescale 1ns / 1ps

module spr_rot_map
    import spr_rot_pkg::*;
(
    input  t_in_word  i_word,
    output t_out_word o_word
);

    logic signed [TRIG_W-1:0]  sn;
    logic signed [TRIG_W-1:0]  cs;
    logic signed [OFS_W-1:0]   dx2;
    logic signed [OFS_W-1:0]   dy2;
    logic signed [PROD_W-1:0]  p_xc;
    logic signed [PROD_W-1:0]  p_ys;
    logic signed [PROD_W-1:0]  p_xs;
    logic signed [PROD_W-1:0]  p_yc;
    logic signed [ACC_W-1:0]   px;
    logic signed [ACC_W-1:0]   py;
    logic [ACC_W-1:0]          mag_x;
    logic [ACC_W-1:0]          mag_y;
    logic [COORD_W-1:0]        qx;
    logic [COORD_W-1:0]        qy;
    logic signed [COORD_W-1:0] col;
    logic signed [COORD_W-1:0] row;
    logic                      in_x;
    logic                      in_y;

    always_comb begin
        sn  = sine_q14(i_word.heading_code);
        cs  = sine_q14(8'(i_word.heading_code + 8'd64));
        dx2 = signed'({1'b0, i_word.src_col, 1'b0}) - SPRITE_SPAN;
        dy2 = SPRITE_SPAN - signed'({1'b0, i_word.src_row, 1'b0});

        p_xc = dx2 * cs;
        p_ys = dy2 * sn;
        p_xs = dx2 * sn;
        p_yc = dy2 * cs;

        px = CENTER_X_Q + ACC_W'(p_xc) - ACC_W'(p_ys);
        py = CENTER_Y_Q - (ACC_W'(p_xs) + ACC_W'(p_yc));

        // Round half away from zero on the magnitude.
        mag_x = px[ACC_W-1] ? unsigned'(-px) : unsigned'(px);
        mag_y = py[ACC_W-1] ? unsigned'(-py) : unsigned'(py);
        qx    = COORD_W'((mag_x + HALF_Q) >> FRAC_W);
        qy    = COORD_W'((mag_y + HALF_Q) >> FRAC_W);
        col   = px[ACC_W-1] ? -signed'(qx) : signed'(qx);
        row   = py[ACC_W-1] ? -signed'(qy) : signed'(qy);

        in_x = !col[COORD_W-1] && (col[COORD_W-2:0] < (COORD_W-1)'(PANEL_WIDTH));
        in_y = !row[COORD_W-1] && (row[COORD_W-2:0] < (COORD_W-1)'(PANEL_HEIGHT));

        if (in_x && in_y) begin
            o_word.dest_col  = col[6:0];
            o_word.dest_bank = row[5:3];
            o_word.dest_bit  = row[2:0];
            o_word.on_panel  = 1'b1;
        end else begin
            o_word = '0;
        end
    end

endmodule

// File: dv/sprite_pixel_rotator_unit_checker.sv
// Checker for the sprite pixel rotator: watches both channels, predicts each rotated pixel
// and compares it with the result word. Depends on spr_rot_pkg for geometry and word types.
`timescale 1ns / 1ps

module sprite_pixel_rotator_unit_checker
    import spr_rot_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_word  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_word i_out_word,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int PIXEL_SINE [0:64] = '{
            0,   402,   804,  1205,  1606,  2006,  2404,  2801,
         3196,  3590,  3981,  4370,  4756,  5139,  5520,  5897,
         6270,  6639,  7005,  7366,  7723,  8076,  8423,  8765,
         9102,  9434,  9760, 10080, 10394, 10702, 11003, 11297,
        11585, 11866, 12140, 12406, 12665, 12916, 13160, 13395,
        13623, 13842, 14053, 14256, 14449, 14635, 14811, 14978,
        15137, 15286, 15426, 15557, 15679, 15791, 15893, 15986,
        16069, 16143, 16207, 16261, 16305, 16340, 16364, 16379,
        16384
    };

    t_out_word expected_pixels [$];
    int        mismatches = 0;

    function automatic int heading_sine(input logic [7:0] code);
        int part;
        int mag;
        part = int'(code[5:0]);
        mag  = code[6] ? PIXEL_SINE[64 - part] : PIXEL_SINE[part];
        return code[7] ? -mag : mag;
    endfunction

    function automatic int round_half_away(input int v);
        if (v >= 0) begin
            return (v + 16384) >>> 15;
        end
        return -((16384 - v) >>> 15);
    endfunction

    function automatic t_out_word rotate_onto_panel(input t_in_word w);
        int        sn;
        int        cs;
        int        dx2;
        int        dy2;
        int        col;
        int        row;
        t_out_word r;
        sn  = heading_sine(w.heading_code);
        cs  = heading_sine(8'(w.heading_code + 8'd64));
        dx2 = 2 * int'(w.src_col) - (SPRITE_SIZE - 1);
        dy2 = (SPRITE_SIZE - 1) - 2 * int'(w.src_row);
        col = round_half_away((PANEL_WIDTH - 1) * 16384 + dx2 * cs - dy2 * sn);
        row = round_half_away((PANEL_HEIGHT - 1) * 16384 - (dx2 * sn + dy2 * cs));
        r = '0;
        if (col >= 0 && col < PANEL_WIDTH && row >= 0 && row < PANEL_HEIGHT) begin
            r.dest_col  = 7'(col);
            r.dest_bank = 3'(row >>> 3);
            r.dest_bit  = 3'(row);
            r.on_panel  = 1'b1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                expected_pixels.push_back(rotate_onto_panel(i_in_word));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result word: col %0d bank %0d bit %0d on %0d",
                                 i_out_word.dest_col, i_out_word.dest_bank,
                                 i_out_word.dest_bit, i_out_word.on_panel);
                    end
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_out_word.dest_col !== want.dest_col ||
                        i_out_word.dest_bank !== want.dest_bank ||
                        i_out_word.dest_bit !== want.dest_bit ||
                        i_out_word.on_panel !== want.on_panel) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                     want.dest_col, want.dest_bank, want.dest_bit,
                                     want.on_panel, i_out_word.dest_col,
                                     i_out_word.dest_bank, i_out_word.dest_bit,
                                     i_out_word.on_panel);
                        end
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_pixels.size();
    end

endmodule

// File: dv/sprite_pixel_rotator_unit_tb.sv
// Testbench top for the sprite pixel rotator: drives directed and random pixel words with
// random gaps and output stalls, and reports the verdict. Depends on spr_rot_pkg, the
// unit and sprite_pixel_rotator_unit_checker.
`timescale 1ns / 1ps

module sprite_pixel_rotator_unit_tb;
    import spr_rot_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;
    int        fail_count;
    int        pending;
    int        cycles = 0;
    logic      no_idle = 1'b0;

    sprite_pixel_rotator_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    sprite_pixel_rotator_unit_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_word  (o_out_word),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("sprite_pixel_rotator_unit_tb failed");
            $finish;
        end
    end

    task automatic send_pixel(input int col, input int row, input int heading);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid             <= 1'b1;
        i_in_word.src_col      <= 6'(col);
        i_in_word.src_row      <= 6'(row);
        i_in_word.heading_code <= 8'(heading);
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        int n;
        @(posedge i_clk);
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            n = no_idle ? 0 : $urandom_range(0, 4);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!(o_out_valid && !i_out_stall)) begin
                @(posedge i_clk);
            end
        end
    end

    initial begin
        int col;
        int row;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sprite corners at the quarter turns, then the heading extremes.
        send_pixel(0, 0, 0);
        send_pixel(47, 47, 0);
        send_pixel(0, 47, 64);
        send_pixel(47, 0, 128);
        send_pixel(47, 47, 192);
        send_pixel(0, 0, 255);
        send_pixel(23, 24, 1);
        send_pixel(24, 23, 63);
        send_pixel(12, 35, 65);
        send_pixel(35, 12, 127);
        send_pixel(5, 40, 129);
        send_pixel(40, 5, 191);
        send_pixel(30, 17, 32);
        send_pixel(17, 30, 96);
        // Source pixels mostly beyond the sprite, some landing off the panel.
        send_pixel(63, 63, 0);
        send_pixel(48, 0, 0);
        send_pixel(0, 48, 128);
        send_pixel(63, 0, 64);
        send_pixel(0, 63, 192);
        send_pixel(63, 63, 160);
        send_pixel(63, 63, 255);
        send_pixel(42, 21, 170);

        for (int i = 0; i < 1650; i++) begin
            no_idle <= ((i / 150) % 3 == 2);
            col = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 47) : $urandom_range(48, 63);
            row = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 47) : $urandom_range(48, 63);
            send_pixel(col, row, $urandom_range(0, 255));
        end
        i_in_valid <= 1'b0;
        no_idle    <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("sprite_pixel_rotator_unit_tb passed");
        end else begin
            $display("sprite_pixel_rotator_unit_tb failed");
        end
        $finish;
    end

endmodule
